// ===== rtl/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue core.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH      = 256;
  localparam int WORD_WIDTH = 32;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  localparam int CMD_W      = 3;
  localparam int OUT_W      = 32;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_REAR  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_CLEAR      = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

endpackage

// ===== rtl/deq_ram.sv =====
// ----------------------------------------------------------------------------
// deq_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int DATA_W = 32,
  parameter int ENTRIES = 256,
  parameter int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/double_ended_queue_core.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Double-ended queue of data words held in a ring RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item (cmd, push_word) is taken at a rising edge with
//   start high and busy low. Commands: push front, push rear, pop front,
//   pop rear, peek front, clear; codes six and seven do nothing.
//   Result channel: exactly one item per command, shown on out_word, status
//   and count for one cycle with done high. The receiver cannot stall; the
//   result must be captured in that cycle.
// Timing:
//   The result appears in the cycle right after the command edge, with busy
//   high then, so a new command waits for the last result. The registered
//   read port of the ring RAM sets this beat: pops and peeks fetch their
//   word there, every other command follows the same beat.
// Errors:
//   Pop or peek on an empty queue, or push on a full one, changes nothing and
//   reports the status code; out_word is zero then.
// Reset:
//   rst (synchronous, active high) empties the queue: both ends and the count
//   go to zero. The RAM is not cleared; only held entries are ever read.
// ----------------------------------------------------------------------------
module double_ended_queue_core
  import deq_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [OUT_W-1:0]    push_word,
  output logic                done,
  output logic [OUT_W-1:0]    out_word,
  output logic [STATUS_W-1:0] status,
  output logic [COUNT_W-1:0]  count
);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  // queue bookkeeping
  logic [IDX_W-1:0] front_index, front_index_next;
  logic [IDX_W-1:0] rear_index, rear_index_next;
  logic [CNT_W-1:0] held_count, held_count_next;

  // result bookkeeping
  logic             pending;
  logic             rd_ok, rd_ok_next;
  status_t          status_next;

  // RAM port signals
  logic                  we;
  logic [IDX_W-1:0]      wr_addr;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic [WORD_WIDTH-1:0] rd_data;

  logic             accept;
  logic             empty, full;
  logic [IDX_W-1:0] front_inc, front_dec, rear_inc, rear_dec;

  assign accept = start && !pending;
  assign busy   = pending;
  assign done   = pending;

  assign empty = (held_count == '0);
  assign full  = (held_count == CNT_FULL);

  // wrap-around neighbors; depth need not be a power of two
  assign front_inc = (front_index == IDX_LAST) ? '0 : front_index + 1'b1;
  assign front_dec = (front_index == '0) ? IDX_LAST : front_index - 1'b1;
  assign rear_inc  = (rear_index == IDX_LAST) ? '0 : rear_index + 1'b1;
  assign rear_dec  = (rear_index == '0) ? IDX_LAST : rear_index - 1'b1;

  // command decode: next indices, RAM access and status
  always_comb begin
    front_index_next = front_index;
    rear_index_next  = rear_index;
    held_count_next  = held_count;
    status_next      = STATUS_OK;
    rd_ok_next       = 1'b0;
    we               = 1'b0;
    wr_addr          = rear_index;
    rd_en            = 1'b0;
    rd_addr          = front_index;

    if (accept) begin
      case (cmd)
        CMD_PUSH_FRONT: begin
          if (full) begin
            status_next = STATUS_FULL;
          end else begin
            front_index_next = front_dec;
            we               = 1'b1;
            wr_addr          = front_dec;
            held_count_next  = held_count + 1'b1;
          end
        end
        CMD_PUSH_REAR: begin
          if (full) begin
            status_next = STATUS_FULL;
          end else begin
            rear_index_next = rear_inc;
            we              = 1'b1;
            wr_addr         = rear_index;
            held_count_next = held_count + 1'b1;
          end
        end
        CMD_POP_FRONT: begin
          if (empty) begin
            status_next = STATUS_EMPTY;
          end else begin
            rd_en            = 1'b1;
            rd_addr          = front_index;
            rd_ok_next       = 1'b1;
            front_index_next = front_inc;
            held_count_next  = held_count - 1'b1;
          end
        end
        CMD_POP_REAR: begin
          if (empty) begin
            status_next = STATUS_EMPTY;
          end else begin
            rd_en           = 1'b1;
            rd_addr         = rear_dec;
            rd_ok_next      = 1'b1;
            rear_index_next = rear_dec;
            held_count_next = held_count - 1'b1;
          end
        end
        CMD_PEEK_FRONT: begin
          if (empty) begin
            status_next = STATUS_EMPTY;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = front_index;
            rd_ok_next = 1'b1;
          end
        end
        CMD_CLEAR: begin
          front_index_next = '0;
          rear_index_next  = '0;
          held_count_next  = '0;
        end
        default: begin
        end
      endcase

      // last element gone: both ends return to slot zero
      if (held_count_next == '0) begin
        front_index_next = '0;
        rear_index_next  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_index <= '0;
      rear_index  <= '0;
      held_count  <= '0;
      pending     <= 1'b0;
      rd_ok       <= 1'b0;
      status      <= STATUS_OK;
      count       <= '0;
    end else begin
      front_index <= front_index_next;
      rear_index  <= rear_index_next;
      held_count  <= held_count_next;
      pending     <= accept;
      if (accept) begin
        rd_ok  <= rd_ok_next;
        status <= status_next;
        count  <= COUNT_W'(held_count_next);
      end
    end
  end

  // word comes straight from the registered read port
  assign out_word = rd_ok ? OUT_W'(rd_data) : '0;

  deq_ram #(
    .DATA_W  (WORD_WIDTH),
    .ENTRIES (DEPTH),
    .ADDR_W  (IDX_W)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (push_word[WORD_WIDTH-1:0]),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// ===== rtl/deq_checker.sv =====
// ----------------------------------------------------------------------------
// deq_checker
// Port-level assertions for the double-ended queue core.
// ----------------------------------------------------------------------------
module deq_checker
  import deq_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input logic [OUT_W-1:0]    out_word,
  input logic [STATUS_W-1:0] status,
  input logic [COUNT_W-1:0]  count
);

  // every accepted item gives its result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> done)
    else $error("no result after accepted item");

  // one result per item, never two in a row
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe repeated");

  // error results carry no word
  a_error_word_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status != STATUS_OK) |-> (out_word == '0))
    else $error("error result with nonzero word");

  // full and empty reports agree with the count
  a_status_count: assert property (@(posedge clk) disable iff (rst)
    done |-> ((status != STATUS_FULL) || (count == COUNT_W'(DEPTH))) &&
             ((status != STATUS_EMPTY) || (count == '0)))
    else $error("status disagrees with count");

endmodule

bind double_ended_queue_core deq_checker u_deq_checker (.*);

// ===== tb/double_ended_queue_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_ended_queue_core_tb
// Self-checking bench for the double-ended queue core. A queue of pending
// commands feeds a driver that pushes them through the start/busy handshake
// with random gaps. A monitor keeps its own ring-store model of the deque and
// checks every done strobe field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module double_ended_queue_core_tb;
  import deq_pkg::*;

  // Codes six and seven are not in the command enum; the core must ignore them.
  localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

  localparam int RANDOM_ITEMS = 1450;
  localparam int STALL_LIMIT  = 1000;  // cycles without any handshake
  localparam int TAIL_CYCLES  = 4;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic [OUT_W-1:0] word;
  } deq_item_t;

  typedef struct packed {
    logic [OUT_W-1:0]    word;
    logic [STATUS_W-1:0] stat;
    logic [COUNT_W-1:0]  level;
  } deq_result_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [CMD_W-1:0]    cmd;
  logic [OUT_W-1:0]    push_word;
  logic                done;
  logic [OUT_W-1:0]    out_word;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  count;

  double_ended_queue_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .push_word (push_word),
    .done      (done),
    .out_word  (out_word),
    .status    (status),
    .count     (count)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Stimulus bookkeeping
  // --------------------------------------------------------------------------
  deq_item_t   pending_cmds[$];
  deq_result_t awaited_results[$];
  int          total_cmds;
  int          plan_level;     // element count the plan expects, used for shaping

  // Handshake state shared between monitor (posedge) and driver (negedge)
  bit cmd_taken;
  int cmds_accepted;
  int gap_left;
  int burst_left;              // items still to send back to back

  // Outcome counters
  int mismatches;
  int stray_results;
  int empty_hits;
  int full_hits;
  int peak_level;
  int idle_cycles;

  // --------------------------------------------------------------------------
  // Deque model: ring store, front slot, slot past the rear, element count
  // --------------------------------------------------------------------------
  logic [WORD_WIDTH-1:0] ring_mem [DEPTH];
  logic [IDX_W-1:0]      front_ptr;
  logic [IDX_W-1:0]      rear_ptr;
  logic [CNT_W-1:0]      level;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] p);
    return (p == IDX_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] p);
    return (p == '0) ? IDX_W'(DEPTH - 1) : p - 1'b1;
  endfunction

  // Applies one command to the model and returns the result the core owes.
  function automatic deq_result_t apply_deq_cmd(input deq_item_t it);
    deq_result_t r;
    r.word = '0;
    r.stat = STATUS_OK;
    case (it.op)
      CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
        if (level >= CNT_W'(DEPTH)) begin
          r.stat = STATUS_FULL;
        end else if (it.op == CMD_PUSH_FRONT) begin
          front_ptr = ring_prev(front_ptr);
          ring_mem[front_ptr] = it.word[WORD_WIDTH-1:0];
          level++;
        end else begin
          ring_mem[rear_ptr] = it.word[WORD_WIDTH-1:0];
          rear_ptr = ring_next(rear_ptr);
          level++;
        end
      end
      CMD_POP_FRONT, CMD_POP_REAR, CMD_PEEK_FRONT: begin
        if (level == '0) begin
          r.stat = STATUS_EMPTY;
        end else if (it.op == CMD_PEEK_FRONT) begin
          r.word = OUT_W'(ring_mem[front_ptr]);
        end else begin
          if (it.op == CMD_POP_FRONT) begin
            r.word = OUT_W'(ring_mem[front_ptr]);
            front_ptr = ring_next(front_ptr);
          end else begin
            rear_ptr = ring_prev(rear_ptr);
            r.word = OUT_W'(ring_mem[rear_ptr]);
          end
          level--;
          // last element gone: both ends snap back to slot zero
          if (level == '0) begin
            front_ptr = '0;
            rear_ptr  = '0;
          end
        end
      end
      CMD_CLEAR: begin
        front_ptr = '0;
        rear_ptr  = '0;
        level     = '0;
      end
      default: ;  // unused codes: no change
    endcase
    r.level = COUNT_W'(level);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Plan helpers: queue a command and track the count it leads to
  // --------------------------------------------------------------------------
  function automatic logic [OUT_W-1:0] pick_word();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  task automatic queue_cmd(input logic [CMD_W-1:0] op, input logic [OUT_W-1:0] w);
    deq_item_t it;
    it.op   = op;
    it.word = w;
    pending_cmds.push_back(it);
    case (op)
      CMD_PUSH_FRONT, CMD_PUSH_REAR: if (plan_level < DEPTH) plan_level++;
      CMD_POP_FRONT, CMD_POP_REAR:   if (plan_level > 0) plan_level--;
      CMD_CLEAR:                     plan_level = 0;
      default: ;
    endcase
  endtask

  task automatic queue_push();
    queue_cmd($urandom_range(0, 1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT, pick_word());
  endtask

  task automatic queue_pop();
    queue_cmd($urandom_range(0, 1) ? CMD_POP_REAR : CMD_POP_FRONT, pick_word());
  endtask

  task automatic queue_noise();
    queue_cmd($urandom_range(0, 1) ? CMD_UNUSED_7 : CMD_UNUSED_6, pick_word());
  endtask

  // Any command at all, weighted toward the data path
  task automatic queue_any();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35)      queue_push();
    else if (r < 65) queue_pop();
    else if (r < 82) queue_cmd(CMD_PEEK_FRONT, pick_word());
    else if (r < 86) queue_cmd(CMD_CLEAR, pick_word());
    else if (r < 92) queue_noise();
    else             queue_push();
  endtask

  // Gap after an item: mostly none or short, now and then long, and
  // occasional stretches with no gaps at all.
  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: inputs change on the falling edge only
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    deq_item_t it;
    if (rst) begin
      start     <= 1'b0;
      cmd       <= '0;
      push_word <= '0;
    end else if (!start || cmd_taken) begin
      // previous item gone (or none in flight): idle or present the next one
      if (gap_left > 0 || pending_cmds.size() == 0) begin
        if (gap_left > 0) gap_left--;
        start     <= 1'b0;
        cmd       <= CMD_W'($urandom);   // junk while idle, must be ignored
        push_word <= $urandom;
      end else begin
        it        = pending_cmds[0];
        pending_cmds.delete(0);
        start     <= 1'b1;
        cmd       <= it.op;
        push_word <= it.word;
        gap_left  = pick_gap();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: samples on the rising edge, checks results, then predicts
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    deq_result_t want;
    deq_item_t   it;
    cmd_taken = 1'b0;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (done) begin
        if (awaited_results.size() == 0) begin
          stray_results++;
          $display("%0t: result with nothing pending: word=%h status=%0d count=%0d",
                   $realtime, out_word, status, count);
        end else begin
          want = awaited_results[0];
          awaited_results.delete(0);
          if (out_word !== want.word || status !== want.stat || count !== want.level) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: mismatch word %h/%h status %0d/%0d count %0d/%0d (exp/got)",
                       $realtime, want.word, out_word, want.stat, status,
                       want.level, count);
          end
        end
      end

      if (start && !busy) begin
        cmd_taken = 1'b1;
        it.op     = cmd;
        it.word   = push_word;
        want      = apply_deq_cmd(it);
        if (want.stat == STATUS_EMPTY) empty_hits++;
        if (want.stat == STATUS_FULL)  full_hits++;
        if (int'(level) > peak_level)  peak_level = int'(level);
        awaited_results.push_back(want);
        cmds_accepted++;
      end

      // watchdog: no command taken and no result seen
      if (cmd_taken || done) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $realtime, STALL_LIMIT, awaited_results.size());
        $display("double_ended_queue_core_tb NOT OK");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus plan, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    int phase;
    int n;
    rst           = 1'b1;
    start         = 1'b0;
    cmd           = '0;
    push_word     = '0;
    front_ptr     = '0;
    rear_ptr      = '0;
    level         = '0;
    plan_level    = 0;
    gap_left      = 0;
    burst_left    = 0;
    cmds_accepted = 0;
    mismatches    = 0;
    stray_results = 0;
    empty_hits    = 0;
    full_hits     = 0;
    peak_level    = 0;
    idle_cycles   = 0;

    // Directed: empty-queue errors, extremes of the word, front push wrapping
    // below slot zero, both pops, peek, unused codes, clear, last-pop reset.
    queue_cmd(CMD_POP_FRONT,  32'hFFFF_FFFF);
    queue_cmd(CMD_POP_REAR,   32'h0000_0000);
    queue_cmd(CMD_PEEK_FRONT, 32'h1234_5678);
    queue_cmd(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
    queue_cmd(CMD_PUSH_REAR,  32'h0000_0000);
    queue_cmd(CMD_PUSH_FRONT, 32'hAAAA_AAAA);
    queue_cmd(CMD_PUSH_REAR,  32'h5555_5555);
    queue_cmd(CMD_PEEK_FRONT, 32'h0);
    queue_cmd(CMD_UNUSED_6,   32'hDEAD_BEEF);
    queue_cmd(CMD_UNUSED_7,   32'hFFFF_FFFF);
    queue_cmd(CMD_POP_REAR,   32'h0);
    queue_cmd(CMD_POP_FRONT,  32'h0);
    queue_cmd(CMD_POP_FRONT,  32'h0);
    queue_cmd(CMD_POP_REAR,   32'h0);      // last element: ends back at zero
    queue_cmd(CMD_POP_REAR,   32'h0);      // empty again
    queue_cmd(CMD_PUSH_REAR,  32'h8000_0001);
    queue_cmd(CMD_PUSH_FRONT, 32'h7FFF_FFFE);
    queue_cmd(CMD_CLEAR,      32'hFFFF_FFFF);
    queue_cmd(CMD_PEEK_FRONT, 32'h0);
    queue_cmd(CMD_PUSH_FRONT, 32'hC3C3_3C3C);
    queue_cmd(CMD_POP_REAR,   32'h0);
    queue_cmd(CMD_CLEAR,      32'h0);      // clear of an empty queue

    // Random: phases of filling to full, draining to empty, mixed traffic
    // and clears, with a sprinkle of peeks and unused codes everywhere.
    total_cmds = pending_cmds.size() + RANDOM_ITEMS;
    while (pending_cmds.size() < total_cmds) begin
      phase = $urandom_range(0, 9);
      if (phase < 3) begin
        while (plan_level < DEPTH && pending_cmds.size() < total_cmds) begin
          n = $urandom_range(0, 99);
          if (n < 8)       queue_cmd(CMD_PEEK_FRONT, pick_word());
          else if (n < 13) queue_pop();
          else if (n < 15) queue_noise();
          else             queue_push();
        end
        repeat ($urandom_range(1, 3)) queue_push();   // pushes into a full queue
      end else if (phase < 6) begin
        while (plan_level > 0 && pending_cmds.size() < total_cmds) begin
          n = $urandom_range(0, 99);
          if (n < 10)      queue_cmd(CMD_PEEK_FRONT, pick_word());
          else if (n < 15) queue_push();
          else if (n < 17) queue_noise();
          else             queue_pop();
        end
        repeat ($urandom_range(1, 2)) begin
          if ($urandom_range(0, 2) == 0) queue_cmd(CMD_PEEK_FRONT, pick_word());
          else                           queue_pop();
        end
      end else if (phase < 9) begin
        repeat ($urandom_range(10, 50)) queue_any();
      end else begin
        queue_cmd(CMD_CLEAR, pick_word());
      end
    end
    total_cmds = pending_cmds.size();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (cmds_accepted < total_cmds || awaited_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Ran %0d commands; peak fill %0d of %0d, %0d empty-queue and %0d full-queue errors",
             total_cmds, peak_level, DEPTH, empty_hits, full_hits);
    $display("Mismatching results: %0d, results with nothing pending: %0d",
             mismatches, stray_results);
    if (mismatches == 0 && stray_results == 0 && awaited_results.size() == 0) begin
      $display("double_ended_queue_core_tb OK");
    end else begin
      $display("double_ended_queue_core_tb NOT OK");
    end
    $finish;
  end

endmodule
